### rtl/core/stps_pkg.sv
// Shared types, constants and arithmetic helpers for the sine partial-sum block.
`default_nettype none

package stps_pkg;

  // Field widths
  localparam int ANGLE_W = 16;
  localparam int TERM_W  = 4;
  localparam int PSUM_W  = 24;
  localparam int WORD_W  = 32;

  // Degree to radian: floor(pi/180 * 2^32), angle carries 6 fraction bits
  localparam int               RAD_W           = 27;
  localparam logic [RAD_W-1:0] RAD_PER_DEG_Q32 = 27'd74961320;
  localparam int               ANGLE_FRAC_BITS = 6;

  // Per-term divisor (2k-2)(2k-1) and floor(2^34 / divisor), indexed by term number
  localparam int DIV_W       = 9;
  localparam int DIVQ_W      = 25;
  localparam int RECIP_SHIFT = 34;
  localparam logic [DIV_W-1:0] TERM_DIV [0:10] = '{
    9'd0, 9'd0, 9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342
  };
  localparam logic [WORD_W-1:0] TERM_RECIP [0:10] = '{
    32'd0, 32'd0, 32'd2863311530, 32'd858993459, 32'd409044504, 32'd238609294,
    32'd156180628, 32'd110127366, 32'd81808900, 32'd63161283, 32'd50233535
  };

  // Register map
  localparam int   PADDR_W        = 3;
  localparam int   PDATA_W        = 32;
  localparam logic REG_TERM_COUNT = 1'b0;

  // Term handed from one cell to the next
  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] op;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] x2;
    logic [TERM_W-1:0] cnt;
  } link_t;

  // Result offered by a cell to the output register
  typedef struct packed {
    logic              req;
    logic [PSUM_W-1:0] psum;
    logic [TERM_W-1:0] terms;
    logic              last;
  } res_t;

  // Signed 32-bit add, saturating
  function automatic logic [WORD_W-1:0] sat_add32(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) begin
      sat_add32 = s[WORD_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat_add32 = s[WORD_W-1:0];
    end
  endfunction

  // Signed 32-bit to 24-bit, saturating
  function automatic logic [PSUM_W-1:0] sat24(input logic [WORD_W-1:0] v);
    if (v[WORD_W-1:PSUM_W-1] == {(WORD_W-PSUM_W+1){v[WORD_W-1]}}) begin
      sat24 = v[PSUM_W-1:0];
    end else begin
      sat24 = v[WORD_W-1] ? 24'h80_0000 : 24'h7F_FFFF;
    end
  endfunction

  // Next term: magnitude q (at most 2^31) with the sign opposite to op
  function automatic logic [WORD_W-1:0] next_term(input logic [WORD_W-1:0] op,
                                                  input logic [WORD_W-1:0] q);
    if (op[WORD_W-1]) begin
      next_term = q[WORD_W-1] ? 32'h7FFF_FFFF : q;
    end else begin
      next_term = 32'd0 - q;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/sine_taylor_partial_sums_top.sv
// Top level: APB register, angle front end, row of term cells and output register.
//
// Sine by Taylor partial sums. One angle beat (in_angle_degrees, signed, 1/64
// degree) yields term_count result beats, one per term k = 1..count, each with
// the saturated Q8.16 partial sum, k in out_terms_used and out_last on the final one.
// Channels are valid/ready; an APB port holds term_count (byte address 0, reset 1).
// Each further term is done once its cell's multiplier has run the product, a
// rounding step and two reciprocal divide passes (only the product and the
// rounding step when the term saturates). One angle is in the row at a time:
// in_ready is low from accept until the last result of that angle is in the
// output register, so the next angle goes in while that result still waits.
// When the output register is full and out_ready is low, the active cell holds
// its sum and the row stops until the register frees. Reset clears all valids
// and cell sequencers and sets term_count to 1; no clearing pass.
`default_nettype none

module sine_taylor_partial_sums_top #(
  parameter int MAX_TERMS     = 10,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output      logic                                 in_ready,
  input  wire logic signed [stps_pkg::ANGLE_W-1:0]  in_angle_degrees,
  output      logic                                 out_valid,
  input  wire logic                                 out_ready,
  output      logic signed [stps_pkg::PSUM_W-1:0]   out_partial_sum,
  output      logic        [stps_pkg::TERM_W-1:0]   out_terms_used,
  output      logic                                 out_last,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic        [stps_pkg::PADDR_W-1:0]  paddr,
  input  wire logic        [stps_pkg::PDATA_W-1:0]  pwdata,
  output      logic        [stps_pkg::PDATA_W-1:0]  prdata,
  output      logic                                 pready
);

  logic [stps_pkg::TERM_W-1:0] term_count_r;
  logic                        busy_r;
  logic                        out_valid_r;
  logic [stps_pkg::PSUM_W-1:0] out_psum_r;
  logic [stps_pkg::TERM_W-1:0] out_terms_r;
  logic                        out_last_r;

  logic                        in_fire;
  logic                        cfg_wr;
  logic                        grant;
  logic                        out_load;
  stps_pkg::link_t             lnk [0:MAX_TERMS];
  stps_pkg::res_t              res [1:MAX_TERMS];
  stps_pkg::res_t              sel;
  logic [MAX_TERMS-1:0]        req_vec;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == stps_pkg::REG_TERM_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= 4'd1;
    end else if (cfg_wr) begin
      term_count_r <= pwdata[stps_pkg::TERM_W-1:0];
    end
  end

  assign prdata = (paddr[2] == stps_pkg::REG_TERM_COUNT) ?
                  stps_pkg::PDATA_W'(term_count_r) : '0;

  // Input handshake
  assign in_ready = !busy_r;
  assign in_fire  = in_valid && in_ready;

  stps_conv #(
    .FRACTION_BITS (FRACTION_BITS),
    .MAX_TERMS     (MAX_TERMS)
  ) u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_fire),
    .angle      (in_angle_degrees),
    .term_count (term_count_r),
    .lnk_o      (lnk[0])
  );

  // Row of term cells
  for (genvar g = 1; g <= MAX_TERMS; g++) begin : g_cell
    stps_cell #(
      .K             (g),
      .FRACTION_BITS (FRACTION_BITS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .lnk_i (lnk[g-1]),
      .grant (grant),
      .lnk_o (lnk[g]),
      .res_o (res[g])
    );
    assign req_vec[g-1] = res[g].req;
  end

  // Only one cell is active, so the result select is an OR
  always_comb begin
    sel = '0;
    for (int i = 1; i <= MAX_TERMS; i++) begin
      if (res[i].req) begin
        sel = sel | res[i];
      end
    end
  end

  assign grant    = !out_valid_r || out_ready;
  assign out_load = sel.req && grant;

  // Busy from accept until the last beat of that angle is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_r <= 1'b1;
      end else if (out_load && sel.last) begin
        busy_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_psum_r  <= sel.psum;
      out_terms_r <= sel.terms;
      out_last_r  <= sel.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_partial_sum = out_psum_r;
  assign out_terms_used  = out_terms_r;
  assign out_last        = out_last_r;

`ifndef ASSERT_OFF
  // At most one cell offers a result at a time
  a_one_cell: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(req_vec))
    else $error("more than one cell offers a result");

  // The final cell never passes a term on
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !lnk[MAX_TERMS].vld)
    else $error("term passed beyond the last cell");

  // A cell only works on an accepted angle
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sel.req |-> busy_r)
    else $error("result offered while idle");

  // Busy drops only after the last beat of an angle was loaded
  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(out_load && sel.last))
    else $error("busy cleared without a last beat");
`endif

endmodule

`default_nettype wire

### rtl/core/stps_conv.sv
// Front end: angle to radians x and x squared, then the first term to the cell row.
`default_nettype none

module stps_conv #(
  parameter int FRACTION_BITS = 16,
  parameter int MAX_TERMS     = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [stps_pkg::ANGLE_W-1:0] angle,
  input  wire logic        [stps_pkg::TERM_W-1:0]  term_count,
  output stps_pkg::link_t                          lnk_o
);

  localparam int XMW = FRACTION_BITS + 4;
  localparam int X2W = FRACTION_BITS + 7;
  localparam int APW = stps_pkg::ANGLE_W + stps_pkg::RAD_W;
  localparam int ASH = 32 + stps_pkg::ANGLE_FRAC_BITS - FRACTION_BITS;
  localparam int SQW = 2 * XMW;

  logic [4:0]                      vld_r;
  logic                            neg_r;
  logic [stps_pkg::ANGLE_W-1:0]    amag_r;
  logic [stps_pkg::TERM_W-1:0]     cnt_r;
  logic [stps_pkg::TERM_W-1:0]     cnt_nxt;
  logic [APW-1:0]                  aprod_r;
  logic [XMW-1:0]                  xmag_r;
  logic [SQW-1:0]                  sq_r;
  logic [X2W-1:0]                  x2_r;
  logic [APW:0]                    around;
  logic [SQW:0]                    sround;

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], start};
    end
  end

  // Zero and overlarge counts fold into the legal range
  always_comb begin
    if (term_count == '0) begin
      cnt_nxt = 4'd1;
    end else if (term_count > 4'(MAX_TERMS)) begin
      cnt_nxt = 4'(MAX_TERMS);
    end else begin
      cnt_nxt = term_count;
    end
  end

  // Capture sign, magnitude and count at accept
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= angle[stps_pkg::ANGLE_W-1];
      amag_r <= angle[stps_pkg::ANGLE_W-1] ? (16'd0 - angle) : angle;
      cnt_r  <= cnt_nxt;
    end
  end

  // Round to nearest on both rescales
  assign around = {1'b0, aprod_r} + ((APW+1)'(1) << (ASH - 1));
  assign sround = {1'b0, sq_r} + ((SQW+1)'(1) << (FRACTION_BITS - 1));

  // Free-running datapath; only one angle is in flight at a time
  always_ff @(posedge clk) begin
    aprod_r <= APW'(amag_r) * APW'(stps_pkg::RAD_PER_DEG_Q32);
    xmag_r  <= XMW'(around >> ASH);
    sq_r    <= SQW'(xmag_r) * SQW'(xmag_r);
    x2_r    <= X2W'(sround >> FRACTION_BITS);
  end

  // First term is x itself, sum starts at zero
  always_comb begin
    lnk_o.vld = vld_r[4];
    lnk_o.op  = neg_r ? (32'd0 - 32'(xmag_r)) : 32'(xmag_r);
    lnk_o.sum = '0;
    lnk_o.x2  = 32'(x2_r);
    lnk_o.cnt = cnt_r;
  end

endmodule

`default_nettype wire

### rtl/core/stps_cell.sv
// One series term: scales the previous term by x^2/((2k-2)(2k-1)), adds it, emits the sum.
`default_nettype none

module stps_cell #(
  parameter int K             = 1,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire stps_pkg::link_t lnk_i,
  input  wire logic            grant,
  output stps_pkg::link_t      lnk_o,
  output stps_pkg::res_t       res_o
);

  localparam int X2W = FRACTION_BITS + 7;
  localparam int QW  = stps_pkg::DIVQ_W;
  localparam logic [stps_pkg::DIV_W-1:0]  D   = stps_pkg::TERM_DIV[K];
  localparam logic [stps_pkg::WORD_W-1:0] RCP = stps_pkg::TERM_RECIP[K];

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_NORM = 7'b0000100,
    ST_RA   = 7'b0001000,
    ST_RB   = 7'b0010000,
    ST_RC   = 7'b0100000,
    ST_ADD  = 7'b1000000
  } state_t;

  state_t       state_r, state_nxt;
  logic         pass_r, pass_nxt;

  logic [31:0]  op_r, op_nxt;
  logic [31:0]  sum_r, sum_nxt;
  logic [X2W-1:0] x2_r, x2_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic [63:0]  prod_r, prod_nxt;
  logic [QW-1:0] xdiv_r, xdiv_nxt;
  logic [15:0]  lo_r, lo_nxt;
  logic [QW-1:0] q0_r, q0_nxt;
  logic [QW-1:0] qh_r, qh_nxt;

  logic [31:0]  mag;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  nfull, mfull;
  logic         sat;
  logic [QW-1:0] rem, rstep, qstep;
  logic         fix;
  logic [31:0]  qfull;
  logic [31:0]  sum_new;
  logic         is_last;

  // Shared multiplier operands per step
  assign mag = op_r[31] ? (32'd0 - op_r) : op_r;

  always_comb begin
    case (state_r)
      ST_MUL: begin
        mul_a = mag;
        mul_b = 32'(x2_r);
      end
      ST_RA: begin
        mul_a = 32'(xdiv_r);
        mul_b = RCP;
      end
      ST_RB: begin
        mul_a = 32'(prod_r[stps_pkg::RECIP_SHIFT +: QW]);
        mul_b = 32'(D);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = {32'd0, mul_a} * {32'd0, mul_b};

  // Rounded quotient dividend and overflow check against 2^31 * D
  assign nfull = prod_r + (64'(D) << (FRACTION_BITS - 1));
  assign mfull = nfull >> FRACTION_BITS;
  assign sat   = (mfull >> 31) >= 64'(D);

  // Reciprocal estimate is low by at most one; fix it up
  assign rem   = xdiv_r - prod_r[QW-1:0];
  assign fix   = rem >= QW'(D);
  assign qstep = fix ? (q0_r + QW'(1)) : q0_r;
  assign rstep = fix ? (rem - QW'(D)) : rem;
  assign qfull = (32'(qh_r) << 16) + 32'(qstep);

  assign sum_new = stps_pkg::sat_add32(sum_r, op_r);
  assign is_last = (cnt_r == 4'(K));

  // Sequencer and datapath next values
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    op_nxt    = op_r;
    sum_nxt   = sum_r;
    x2_nxt    = x2_r;
    cnt_nxt   = cnt_r;
    xdiv_nxt  = xdiv_r;
    lo_nxt    = lo_r;
    q0_nxt    = q0_r;
    qh_nxt    = qh_r;
    case (state_r)
      ST_IDLE: begin
        if (lnk_i.vld) begin
          op_nxt    = lnk_i.op;
          sum_nxt   = lnk_i.sum;
          x2_nxt    = X2W'(lnk_i.x2);
          cnt_nxt   = lnk_i.cnt;
          state_nxt = (K == 1) ? ST_ADD : ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (sat) begin
          op_nxt    = stps_pkg::next_term(op_r, 32'h8000_0000);
          state_nxt = ST_ADD;
        end else begin
          xdiv_nxt  = {1'b0, mfull[39:16]};
          lo_nxt    = mfull[15:0];
          pass_nxt  = 1'b0;
          state_nxt = ST_RA;
        end
      end
      ST_RA: begin
        state_nxt = ST_RB;
      end
      ST_RB: begin
        q0_nxt    = prod_r[stps_pkg::RECIP_SHIFT +: QW];
        state_nxt = ST_RC;
      end
      ST_RC: begin
        if (!pass_r) begin
          // upper quotient digits done, remainder carries into the low half
          qh_nxt    = qstep;
          xdiv_nxt  = {rstep[stps_pkg::DIV_W-1:0], lo_r};
          pass_nxt  = 1'b1;
          state_nxt = ST_RA;
        end else begin
          op_nxt    = stps_pkg::next_term(op_r, qfull);
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (grant) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    sum_r  <= sum_nxt;
    x2_r   <= x2_nxt;
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    xdiv_r <= xdiv_nxt;
    lo_r   <= lo_nxt;
    q0_r   <= q0_nxt;
    qh_r   <= qh_nxt;
  end

  // Offer the partial sum; pass the term on once it is taken
  always_comb begin
    res_o.req   = (state_r == ST_ADD);
    res_o.psum  = stps_pkg::sat24(sum_new);
    res_o.terms = 4'(K);
    res_o.last  = is_last;

    lnk_o.vld = (state_r == ST_ADD) && grant && !is_last;
    lnk_o.op  = op_r;
    lnk_o.sum = sum_new;
    lnk_o.x2  = 32'(x2_r);
    lnk_o.cnt = cnt_r;
  end

endmodule

`default_nettype wire

### bench/sine_sum_checker.sv
// Result checker for the sine partial-sum block: tracks term_count, predicts every result beat, compares.
`timescale 1ns / 100ps

module sine_sum_checker #(
  parameter int MAX_TERMS     = 10,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [stps_pkg::ANGLE_W-1:0]        in_angle_degrees,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [stps_pkg::PSUM_W-1:0]         out_partial_sum,
  input  logic [stps_pkg::TERM_W-1:0]         out_terms_used,
  input  logic                                out_last,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stps_pkg::PADDR_W-1:0]        paddr,
  input  logic [stps_pkg::PDATA_W-1:0]        pwdata,
  input  logic                                pready,
  output int                                  fail_count,
  output int                                  pending_sums
);

  localparam int AW = stps_pkg::PADDR_W;
  localparam logic [AW-1:0] TERM_COUNT_ADDR = AW'(4 * int'(stps_pkg::REG_TERM_COUNT));

  typedef struct packed {
    logic [stps_pkg::PSUM_W-1:0] psum;
    logic [stps_pkg::TERM_W-1:0] terms;
    logic                        last;
  } sum_beat_t;

  sum_beat_t                   sum_q[$];
  sum_beat_t                   want;
  logic [stps_pkg::TERM_W-1:0] term_count_reg;

  // Unsigned divide, rounded to nearest with ties away from zero
  function automatic logic [63:0] rounded_quotient(input logic [63:0] num,
                                                   input logic [63:0] den);
    return (num + (den >> 1)) / den;
  endfunction

  function automatic longint clamp_signed(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Expected beats for one angle: one partial sum per term up to the effective count
  function automatic void predict_partial_sums(input logic [stps_pkg::ANGLE_W-1:0] angle,
                                               input logic [stps_pkg::TERM_W-1:0] count_reg);
    logic [63:0] angle_mag;
    logic [63:0] x_mag;
    logic [63:0] x_sq;
    logic [63:0] term_mag;
    logic [63:0] quot;
    longint      term;
    longint      total;
    int          n;
    int          k;
    sum_beat_t   beat;
    angle_mag = angle[15] ? 64'h1_0000 - {48'd0, angle} : {48'd0, angle};
    x_mag = rounded_quotient(angle_mag * 64'(stps_pkg::RAD_PER_DEG_Q32),
                             64'd1 << (32 + stps_pkg::ANGLE_FRAC_BITS - FRACTION_BITS));
    x_sq = rounded_quotient(x_mag * x_mag, 64'd1 << FRACTION_BITS);
    // zero means one term, anything past the row length is clipped
    if (count_reg == 0) n = 1;
    else if (int'(count_reg) > MAX_TERMS) n = MAX_TERMS;
    else n = int'(count_reg);
    term = clamp_signed(angle[15] ? -longint'(x_mag) : longint'(x_mag), 32);
    total = 0;
    for (k = 1; k <= n; k++) begin
      if (k > 1) begin
        // next term = -term * x^2 / ((2k-2)(2k-1)), magnitude capped at 2^31
        term_mag = (term < 0) ? 64'(-term) : 64'(term);
        quot = rounded_quotient(term_mag * x_sq,
                                64'((2 * k - 2) * (2 * k - 1)) << FRACTION_BITS);
        if (quot > 64'h8000_0000) quot = 64'h8000_0000;
        term = clamp_signed((term < 0) ? longint'(quot) : -longint'(quot), 32);
      end
      total = clamp_signed(total + term, 32);
      beat.psum  = stps_pkg::PSUM_W'(clamp_signed(total, stps_pkg::PSUM_W));
      beat.terms = stps_pkg::TERM_W'(k);
      beat.last  = (k == n);
      sum_q.push_back(beat);
    end
  endfunction

  task automatic report_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // Accepted angle first: a register write never shares an edge with one
  always @(posedge clk) begin
    if (!rst_n) begin
      term_count_reg = 4'd1;
      sum_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) predict_partial_sums(in_angle_degrees, term_count_reg);
      if (out_valid && out_ready) begin
        if (sum_q.size() == 0) begin
          report_failure($sformatf("unexpected result beat: sum %0d terms %0d last %0b",
                                   $signed(out_partial_sum), out_terms_used, out_last));
        end else begin
          want = sum_q.pop_front();
          if (out_partial_sum !== want.psum || out_terms_used !== want.terms ||
              out_last !== want.last) begin
            report_failure($sformatf(
              "result mismatch: sum %0d/%0d terms %0d/%0d last %0b/%0b (expected/actual)",
              $signed(want.psum), $signed(out_partial_sum), want.terms, out_terms_used,
              want.last, out_last));
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == TERM_COUNT_ADDR)
        term_count_reg = pwdata[stps_pkg::TERM_W-1:0];
    end
    pending_sums = sum_q.size();
  end

endmodule

### bench/testbench.sv
// Top of the sine partial-sum bench: clock, reset, angle and register stimulus, verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int AW             = stps_pkg::PADDR_W;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int RANDOM_PHASES  = 6;
  localparam int ANGLES_PER_PHASE = 50;
  localparam logic [AW-1:0] TERM_COUNT_ADDR = AW'(4 * int'(stps_pkg::REG_TERM_COUNT));
  // first word past the register map; writes there must be dropped
  localparam logic [AW-1:0] SPARE_ADDR = AW'(4);

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [stps_pkg::ANGLE_W-1:0]  in_angle_degrees = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [stps_pkg::PSUM_W-1:0]   out_partial_sum;
  logic [stps_pkg::TERM_W-1:0]   out_terms_used;
  logic                          out_last;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [AW-1:0]                 paddr = '0;
  logic [stps_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [stps_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  int fail_count;
  int pending_sums;
  int quiet_cycles = 0;
  int stall_left = 0;
  int gap_draw;
  bit source_steady = 1'b0;
  bit sink_steady = 1'b0;
  int phase;
  logic [stps_pkg::TERM_W-1:0] phase_count;

  sine_taylor_partial_sums_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_angle_degrees (in_angle_degrees),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_partial_sum  (out_partial_sum),
    .out_terms_used   (out_terms_used),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  sine_sum_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_angle_degrees (in_angle_degrees),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_partial_sum  (out_partial_sum),
    .out_terms_used   (out_terms_used),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .fail_count       (fail_count),
    .pending_sums     (pending_sums)
  );

  always #5 clk = ~clk;

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Angles mostly within one turn, some near zero, some over the whole field
  function automatic logic [stps_pkg::ANGLE_W-1:0] random_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return stps_pkg::ANGLE_W'(int'($urandom_range(0, 46080)) - 23040);
    if (r < 85) return stps_pkg::ANGLE_W'(int'($urandom_range(0, 640)) - 320);
    return stps_pkg::ANGLE_W'($urandom());
  endfunction

  // Result side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_steady) begin
      out_ready <= 1'b1;
    end else begin
      gap_draw = pick_gap();
      out_ready <= (gap_draw == 0);
      stall_left <= (gap_draw > 0) ? gap_draw - 1 : 0;
    end
  end

  // Watchdog: ends the run after too long without any beat or register write
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("sine_taylor_partial_sums_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One angle beat; valid stays up when no gap is drawn
  task automatic send_angle(input logic [stps_pkg::ANGLE_W-1:0] angle);
    int gap;
    gap = source_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle_degrees <= angle;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every expected beat has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_sums == 0);
    @(posedge clk);
  endtask

  task automatic write_apb(input logic [AW-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Upper data bits are junk; only the low nibble is the register
  task automatic set_term_count(input logic [stps_pkg::TERM_W-1:0] count);
    logic [31:0] junk;
    junk = $urandom();
    write_apb(TERM_COUNT_ADDR, {junk[31:stps_pkg::TERM_W], count});
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset count of one term
    send_angle(16'd5760);
    send_angle(16'h8000);
    send_angle(16'h7FFF);

    // full row of ten terms, field extremes and one turn each way
    settle();
    set_term_count(4'd10);
    send_angle(16'd0);
    send_angle(16'd1);
    send_angle(16'hFFFF);
    send_angle(16'd23040);
    send_angle(-16'sd23040);
    send_angle(16'h7FFF);
    send_angle(16'h8000);
    send_angle(16'd11520);

    // count of zero acts as one term
    settle();
    set_term_count(4'd0);
    send_angle(16'd5760);
    send_angle(-16'sd5760);

    // count past the row is clipped to ten
    settle();
    set_term_count(4'd15);
    send_angle(16'd23040);
    send_angle(16'd100);

    // write past the register map leaves the count alone
    settle();
    write_apb(SPARE_ADDR, 32'h0000_0003);
    send_angle(16'd2880);

    settle();
    set_term_count(4'd7);
    send_angle(16'h5555);
    send_angle(16'hAAAA);

    // random angles, a new count per phase, the two ends first
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      source_steady = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        write_apb(SPARE_ADDR, $urandom());
        @(posedge clk);
      end
      if (phase == 0) phase_count = 4'd10;
      else if (phase == 1) phase_count = 4'd1;
      else phase_count = 4'($urandom_range(0, 15));
      set_term_count(phase_count);
      repeat (ANGLES_PER_PHASE) send_angle(random_angle());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_sums == 0) begin
      $display("sine_taylor_partial_sums_top regression: pass");
    end else begin
      $display("sine_taylor_partial_sums_top regression: fail");
    end
    $finish;
  end

endmodule
